[hdl/epc_pkg.sv]
// ----------------------------------------------------------------------------
// Ethernet packet classifier package
// Shared types, header constants and register codes for the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epc_pkg;

   localparam int PKT_NUM_PORTS = 16;
   localparam int PORT_W        = 4;
   localparam int MASK_W        = 16;

   // Byte offsets within the frame, counted from the destination address.
   localparam logic [15:0] OFS_ETYPE_HI  = 16'd12;
   localparam logic [15:0] OFS_ETYPE_LO  = 16'd13;
   localparam logic [15:0] OFS_ARP_0     = 16'd14;
   localparam logic [15:0] OFS_ARP_1     = 16'd15;
   localparam logic [15:0] OFS_ARP_2     = 16'd16;
   localparam logic [15:0] OFS_ARP_3     = 16'd17;
   localparam logic [15:0] OFS_ARP_4     = 16'd18;
   localparam logic [15:0] OFS_ARP_5     = 16'd19;
   localparam logic [15:0] OFS_NEXT_HDR  = 16'd20;
   localparam logic [15:0] OFS_ICMP_TYPE = 16'd54;

   // Minimum byte counts for each captured field to be meaningful.
   localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
   localparam logic [15:0] MIN_LEN_ARP   = 16'd20;
   localparam logic [15:0] MIN_LEN_NH    = 16'd21;
   localparam logic [15:0] MIN_LEN_ICMP  = 16'd55;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
   // Hardware type Ethernet, protocol IPv4, address lengths 6 and 4.
   localparam logic [47:0] ARP_ETHER_IPV4 = 48'h0001_0800_0604;
   localparam logic [7:0]  PROTO_IPIP     = 8'd4;
   localparam logic [7:0]  PROTO_IPV6     = 8'd41;
   localparam logic [7:0]  PROTO_ICMPV6   = 8'd58;
   localparam logic [7:0]  ND_ROUTER_SOL  = 8'd133;
   localparam logic [7:0]  ND_NEIGH_SOL   = 8'd135;

   typedef enum logic [2:0] {
      VERDICT_DROP     = 3'd0,
      VERDICT_ARP      = 3'd1,
      VERDICT_ND       = 3'd2,
      VERDICT_CT       = 3'd3,
      VERDICT_DECAP    = 3'd4,
      VERDICT_TRANSMIT = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      L3_NONE  = 2'd0,
      L3_IPV4  = 2'd1,
      L3_IPV6  = 2'd2,
      L3_OTHER = 2'd3
   } l3_kind_type;

   typedef enum logic [2:0] {
      REG_VALID_MASK  = 3'd0,
      REG_PHYS_MASK   = 3'd1,
      REG_PROXY_EN    = 3'd2,
      REG_SECOND_PF   = 3'd3,
      REG_PROXY_PORT  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [MASK_W-1:0] valid_mask;
      logic [MASK_W-1:0] phys_mask;
      logic              proxy_en;
      logic [PORT_W-1:0] second_pf;
      logic [PORT_W-1:0] proxy_port;
   } cfg_type;

   typedef struct packed {
      logic [15:0]       count;
      logic [PORT_W-1:0] port;
      logic              l2_eth;
      l3_kind_type       l3;
      logic [15:0]       eth_proto;
      logic [47:0]       arp;
      logic [7:0]        next_hdr;
      logic [7:0]        icmp_type;
   } hdr_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [PORT_W-1:0] tx_port;
      logic [15:0]       inner_l3_type;
      logic [15:0]       outer_l3_type;
      logic [15:0]       payload_length;
   } rsp_type;

endpackage

[hdl/epc_hdr_capture.sv]
// ----------------------------------------------------------------------------
// Header capture
// Counts packet bytes and keeps the ethertype, ARP, next header and ICMPv6
// type bytes. Presents the header state as it stands after the current byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_hdr_capture
   import epc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        data_byte,
   input  logic              first_byte,
   input  logic [PORT_W-1:0] rx_port,
   input  logic              l2_is_ethernet,
   input  l3_kind_type       l3_kind,
   output hdr_type           hdr_next
);

   hdr_type hdr_ff;
   hdr_type hdr_in;
   hdr_type hdr_base;

   always_comb begin
      hdr_base = hdr_ff;
      if (first_byte) begin
         hdr_base        = '0;
         hdr_base.port   = rx_port;
         hdr_base.l2_eth = l2_is_ethernet;
         hdr_base.l3     = l3_kind;
      end

      hdr_in = hdr_base;
      case (hdr_base.count)
         OFS_ETYPE_HI:  hdr_in.eth_proto[15:8]  = data_byte;
         OFS_ETYPE_LO:  hdr_in.eth_proto[7:0]   = data_byte;
         OFS_ARP_0:     hdr_in.arp[47:40]       = data_byte;
         OFS_ARP_1:     hdr_in.arp[39:32]       = data_byte;
         OFS_ARP_2:     hdr_in.arp[31:24]       = data_byte;
         OFS_ARP_3:     hdr_in.arp[23:16]       = data_byte;
         OFS_ARP_4:     hdr_in.arp[15:8]        = data_byte;
         OFS_ARP_5:     hdr_in.arp[7:0]         = data_byte;
         OFS_NEXT_HDR:  hdr_in.next_hdr         = data_byte;
         OFS_ICMP_TYPE: hdr_in.icmp_type        = data_byte;
         default: begin
         end
      endcase

      // The count saturates so that very long packets keep their verdict.
      if (hdr_base.count != COUNT_MAX) begin
         hdr_in.count = hdr_base.count + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else if (advance) begin
         hdr_ff <= hdr_in;
      end
   end

   assign hdr_next = hdr_in;

endmodule

[hdl/epc_decide.sv]
// ----------------------------------------------------------------------------
// Verdict decision
// Turns the captured header state, the port masks and the proxy settings
// into one verdict with its port, L3 types and payload length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_decide
   import epc_pkg::*;
#(
   parameter int NUM_PORTS = PKT_NUM_PORTS
)
(
   input  hdr_type hdr,
   input  cfg_type cfg,
   output rsp_type result
);

   logic        port_exists;
   logic        port_valid;
   logic        port_phys;
   logic        has_etype;
   logic [15:0] etype_eff;
   logic        nd_seen;
   rsp_type     base;

   always_comb begin
      port_exists = (32'(hdr.port) < NUM_PORTS);
      port_valid  = port_exists && cfg.valid_mask[hdr.port];
      port_phys   = port_exists && cfg.phys_mask[hdr.port];
      has_etype   = (hdr.count >= ETH_HDR_LEN);
      etype_eff   = has_etype ? hdr.eth_proto : 16'd0;
      nd_seen     = (hdr.count >= MIN_LEN_ICMP) && (hdr.next_hdr == PROTO_ICMPV6) &&
                    ((hdr.icmp_type == ND_NEIGH_SOL) || (hdr.icmp_type == ND_ROUTER_SOL));

      base = '0;
      base.verdict = VERDICT_DROP;
      if (hdr.l2_eth) begin
         case (hdr.l3)
            L3_NONE: begin
               if ((hdr.count >= MIN_LEN_ARP) && (hdr.arp == ARP_ETHER_IPV4)) begin
                  base.verdict = VERDICT_ARP;
               end
            end
            L3_IPV4: begin
               if (port_valid && !port_phys) begin
                  base.verdict        = VERDICT_CT;
                  base.inner_l3_type  = etype_eff;
                  base.payload_length = has_etype ? hdr.count - ETH_HDR_LEN : 16'd0;
               end
            end
            L3_IPV6: begin
               if (port_valid && port_phys) begin
                  // Tunnel traffic arrives on physical ports only.
                  if (!nd_seen && (hdr.count >= MIN_LEN_NH)) begin
                     if (hdr.next_hdr == PROTO_IPIP) begin
                        base.verdict       = VERDICT_DECAP;
                        base.inner_l3_type = ETHERTYPE_IPV4;
                        base.outer_l3_type = etype_eff;
                     end else if (hdr.next_hdr == PROTO_IPV6) begin
                        base.verdict       = VERDICT_DECAP;
                        base.inner_l3_type = ETHERTYPE_IPV6;
                        base.outer_l3_type = etype_eff;
                     end
                  end
               end else if (port_valid) begin
                  if (nd_seen) begin
                     base.verdict = VERDICT_ND;
                  end else begin
                     base.verdict       = VERDICT_CT;
                     base.inner_l3_type = etype_eff;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      result = base;
      if (cfg.proxy_en && (hdr.port == cfg.proxy_port)) begin
         result         = '0;
         result.verdict = VERDICT_TRANSMIT;
         result.tx_port = cfg.second_pf;
      end else if (cfg.proxy_en && (base.verdict == VERDICT_DROP) &&
                   (hdr.port == cfg.second_pf)) begin
         result         = '0;
         result.verdict = VERDICT_TRANSMIT;
         result.tx_port = cfg.proxy_port;
      end
   end

endmodule

[hdl/ethernet_packet_classifier.sv]
// ----------------------------------------------------------------------------
// Ethernet packet classifier
// A packet's last byte passes the input register, then its verdict goes to the
// result register for rsp. The single-pass header capture between them takes
// one byte per cycle; a last byte waits while rsp holds an untaken verdict.
// Reset clears the header state, the configuration and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_packet_classifier
   import epc_pkg::*;
#(
   parameter int NUM_PORTS = PKT_NUM_PORTS
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic [7:0]  req_tuser,   // [0] first_byte, [4:1] rx_port,
                                    // [5] l2_is_ethernet, [7:6] l3_kind

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [3:0] tx_port, [19:4] inner_l3_type,
                                    // [35:20] outer_l3_type, [51:36] payload_length
   output logic [2:0]  rsp_tuser,   // [2:0] verdict

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Input register
   logic              in_valid_ff;
   logic [7:0]        in_data_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   logic [PORT_W-1:0] in_port_ff;
   logic              in_l2_ff;
   l3_kind_type       in_l3_ff;

   // Result register
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   cfg_type           cfg_ff;
   reg_index_type     reg_sel;
   logic              cfg_write;

   logic              out_free;
   logic              advance;
   hdr_type           hdr_next;
   rsp_type           result;

   // Bytes that end no packet never wait on the result side.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
         in_port_ff  <= req_tuser[4:1];
         in_l2_ff    <= req_tuser[5];
         in_l3_ff    <= l3_kind_type'(req_tuser[7:6]);
      end
   end

   epc_hdr_capture u_capture (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .data_byte      (in_data_ff),
      .first_byte     (in_first_ff),
      .rx_port        (in_port_ff),
      .l2_is_ethernet (in_l2_ff),
      .l3_kind        (in_l3_ff),
      .hdr_next       (hdr_next)
   );

   epc_decide #(
      .NUM_PORTS (NUM_PORTS)
   ) u_decide (
      .hdr    (hdr_next),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.verdict;
   assign rsp_tdata  = {4'd0, rsp_ff.payload_length, rsp_ff.outer_l3_type,
                        rsp_ff.inner_l3_type, rsp_ff.tx_port};

   // Configuration registers
   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[4:2]);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (cfg_write) begin
         case (reg_sel)
            REG_VALID_MASK: cfg_ff.valid_mask <= csr_pwdata[MASK_W-1:0];
            REG_PHYS_MASK:  cfg_ff.phys_mask  <= csr_pwdata[MASK_W-1:0];
            REG_PROXY_EN:   cfg_ff.proxy_en   <= csr_pwdata[0];
            REG_SECOND_PF:  cfg_ff.second_pf  <= csr_pwdata[PORT_W-1:0];
            REG_PROXY_PORT: cfg_ff.proxy_port <= csr_pwdata[PORT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_VALID_MASK: csr_prdata = 32'(cfg_ff.valid_mask);
         REG_PHYS_MASK:  csr_prdata = 32'(cfg_ff.phys_mask);
         REG_PROXY_EN:   csr_prdata = 32'(cfg_ff.proxy_en);
         REG_SECOND_PF:  csr_prdata = 32'(cfg_ff.second_pf);
         REG_PROXY_PORT: csr_prdata = 32'(cfg_ff.proxy_port);
         default:        csr_prdata = 32'd0;
      endcase
   end

   // A result only appears after the last byte of a packet went through.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result raised without a last byte");

   // A target port is reported only with a transmit verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.verdict != VERDICT_TRANSMIT) |-> (rsp_ff.tx_port == '0))
      else $error("tx_port set on a non-transmit verdict");

   // Payload length is reported only for connection tracking.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.verdict != VERDICT_CT) |-> (rsp_ff.payload_length == 16'd0))
      else $error("payload length set on a non-conntrack verdict");

endmodule
